// File: rtl/ipatc_pkg.sv
// Package with the character codes, verdict codes and character classifier for the address classifier.
`timescale 1ns / 1ps

package ipatc_pkg;

	localparam logic [7:0] CHAR_END     = 8'h00;
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_PERCENT = 8'h25;

	localparam logic [1:0] VERDICT_INVALID = 2'd0;
	localparam logic [1:0] VERDICT_V4      = 2'd1;
	localparam logic [1:0] VERDICT_V6      = 2'd2;

	// What the previous byte left behind in the IPv6 grammar.
	localparam logic [1:0] COLON_NONE    = 2'd0;
	localparam logic [1:0] COLON_SINGLE  = 2'd1;
	localparam logic [1:0] COLON_LEADING = 2'd2;
	localparam logic [1:0] COLON_DOUBLE  = 2'd3;

	localparam logic [5:0] MAX_TEXT_LEN     = 6'd45;
	localparam logic [5:0] CHAR_COUNT_MAX   = 6'd63;
	localparam logic [8:0] OCTET_MAX        = 9'd255;
	localparam logic [8:0] OCTET_SAT        = 9'd256;
	localparam logic [1:0] OCTET_DIGITS_MAX = 2'd3;
	localparam logic [2:0] DOTS_NEEDED      = 3'd3;
	localparam logic [2:0] DOT_COUNT_MAX    = 3'd7;
	localparam logic [2:0] GROUP_DIGITS_MAX = 3'd4;
	localparam logic [2:0] GROUP_DIGITS_SAT = 3'd5;
	localparam logic [3:0] GROUP_COUNT_MAX  = 4'd15;
	localparam logic [4:0] GROUPS_FULL      = 5'd8;
	localparam logic [4:0] GROUPS_WITH_GAP  = 5'd7;

	typedef struct packed {
		logic       is_hex;
		logic       is_dec;
		logic [3:0] dec_val;
	} char_class_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		r.is_dec  = c inside {[8'h30:8'h39]};
		r.is_hex  = r.is_dec || (c inside {[8'h41:8'h46], [8'h61:8'h66]});
		r.dec_val = c[3:0];
		return r;
	endfunction

endpackage

// File: rtl/ip_address_text_classifier.sv
// Top level of the IPv4 / IPv6 address text classifier.
`timescale 1ns / 1ps

// Feed the address text one byte per transaction, ending with a zero byte; the zero byte
// yields one verdict (0 invalid, 1 IPv4, 2 IPv6) and the block is ready for the next
// string right away. Each byte is captured in an input register, and the grammar
// trackers take it from there. A terminator's verdict is written into the output
// register at the edge on which the trackers take the terminator, so verdict_valid
// rises when the terminator leaves the input register. A full output register held
// by verdict_stall stalls the input only when the byte waiting in the input register
// is a terminator; ordinary bytes keep flowing while a verdict waits to be taken.
module ip_address_text_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output logic [1:0] verdict
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	logic [1:0] verdict_q;
	logic [1:0] verdict_d;
	logic       out_free, s1_end, s1_fire, accept;

	assign out_free   = !out_valid_q || !verdict_stall;
	assign s1_end     = (char_s1 == ipatc_pkg::CHAR_END);
	assign s1_fire    = valid_s1 && (!s1_end || out_free);
	assign char_stall = valid_s1 && !s1_fire;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			char_s1 <= char_code;
	end

	ipatc_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_fire),
		.char_code (char_s1),
		.verdict_d (verdict_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_end) begin
			out_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_end)
			verdict_q <= verdict_d;
	end

	assign verdict_valid = out_valid_q;
	assign verdict       = verdict_q;

	a_end_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && s1_end) |=> out_valid_q)
		else $error("terminator did not produce a verdict");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (valid_s1 && s1_end && out_valid_q && verdict_stall))
		else $error("input stalled without a blocked terminator");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (verdict_q != 2'd3))
		else $error("verdict code out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_stall) |=> $stable(verdict_q))
		else $error("pending verdict overwritten");

endmodule

// File: rtl/ipatc_tracker.sv
// Grammar state for the IPv4 and IPv6 address checks and the verdict logic.
`timescale 1ns / 1ps

module ipatc_tracker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_code,
	output logic [1:0] verdict_d
);

	ipatc_pkg::char_class_t cls;

	logic       seen_colon_q, seen_dot_q, bad_char_q;
	logic [5:0] char_count_q;
	logic       v4_ok_q;
	logic [8:0] octet_value_q;
	logic [1:0] octet_digits_q;
	logic [2:0] octet_count_q;
	logic       v6_ok_q;
	logic [2:0] group_digits_q;
	logic [3:0] group_count_q;
	logic       double_colon_q;
	logic [1:0] last_colon_q;

	logic       seen_colon_n, seen_dot_n, bad_char_n;
	logic [5:0] char_count_n;
	logic       v4_ok_n;
	logic [8:0] octet_value_n;
	logic [1:0] octet_digits_n;
	logic [2:0] octet_count_n;
	logic       v6_ok_n;
	logic [2:0] group_digits_n;
	logic [3:0] group_count_n;
	logic       double_colon_n;
	logic [1:0] last_colon_n;

	logic        is_colon, is_dot, is_pct, is_end;
	logic [11:0] octet_prod;
	logic        v4_match, v6_match;
	logic [4:0]  groups;

	assign cls      = ipatc_pkg::classify(char_code);
	assign is_colon = (char_code == ipatc_pkg::CHAR_COLON);
	assign is_dot   = (char_code == ipatc_pkg::CHAR_DOT);
	assign is_pct   = (char_code == ipatc_pkg::CHAR_PERCENT);
	assign is_end   = (char_code == ipatc_pkg::CHAR_END);

	// value * 10 + digit; the value is at most 256, so 12 bits always hold it.
	assign octet_prod = {octet_value_q, 3'b000} + {2'b00, octet_value_q, 1'b0}
		+ {8'd0, cls.dec_val};

	always_comb begin
		seen_colon_n   = seen_colon_q | is_colon;
		seen_dot_n     = seen_dot_q | is_dot;
		bad_char_n     = bad_char_q | (!cls.is_hex && !is_colon && !is_dot && !is_pct);
		char_count_n   = (char_count_q < ipatc_pkg::CHAR_COUNT_MAX) ?
			char_count_q + 6'd1 : char_count_q;

		v4_ok_n        = v4_ok_q;
		octet_value_n  = octet_value_q;
		octet_digits_n = octet_digits_q;
		octet_count_n  = octet_count_q;
		if (is_dot) begin
			if (octet_digits_q == 2'd0)
				v4_ok_n = 1'b0;
			if (octet_count_q < ipatc_pkg::DOT_COUNT_MAX)
				octet_count_n = octet_count_q + 3'd1;
			if (octet_count_n > ipatc_pkg::DOTS_NEEDED)
				v4_ok_n = 1'b0;
			octet_digits_n = 2'd0;
			octet_value_n  = 9'd0;
		end else if (cls.is_dec) begin
			// A digit after a lone zero is a leading zero.
			if (octet_digits_q != 2'd0 && octet_value_q == 9'd0)
				v4_ok_n = 1'b0;
			if (octet_digits_q == ipatc_pkg::OCTET_DIGITS_MAX)
				v4_ok_n = 1'b0;
			else
				octet_digits_n = octet_digits_q + 2'd1;
			octet_value_n = (octet_prod > {3'd0, ipatc_pkg::OCTET_SAT}) ?
				ipatc_pkg::OCTET_SAT : octet_prod[8:0];
			if (octet_value_n > ipatc_pkg::OCTET_MAX)
				v4_ok_n = 1'b0;
		end else begin
			v4_ok_n = 1'b0;
		end

		v6_ok_n        = v6_ok_q;
		group_digits_n = group_digits_q;
		group_count_n  = group_count_q;
		double_colon_n = double_colon_q;
		last_colon_n   = last_colon_q;
		if (is_colon) begin
			case (last_colon_q)
				ipatc_pkg::COLON_NONE: begin
					if (group_digits_q == 3'd0) begin
						last_colon_n = ipatc_pkg::COLON_LEADING;
					end else begin
						if (group_count_q < ipatc_pkg::GROUP_COUNT_MAX)
							group_count_n = group_count_q + 4'd1;
						group_digits_n = 3'd0;
						last_colon_n   = ipatc_pkg::COLON_SINGLE;
					end
				end
				ipatc_pkg::COLON_DOUBLE: begin
					v6_ok_n = 1'b0;
				end
				default: begin
					if (double_colon_q)
						v6_ok_n = 1'b0;
					double_colon_n = 1'b1;
					last_colon_n   = ipatc_pkg::COLON_DOUBLE;
				end
			endcase
		end else if (cls.is_hex) begin
			if (last_colon_q == ipatc_pkg::COLON_LEADING)
				v6_ok_n = 1'b0;
			if (group_digits_q < ipatc_pkg::GROUP_DIGITS_SAT)
				group_digits_n = group_digits_q + 3'd1;
			if (group_digits_n > ipatc_pkg::GROUP_DIGITS_MAX)
				v6_ok_n = 1'b0;
			last_colon_n = ipatc_pkg::COLON_NONE;
		end else begin
			v6_ok_n = 1'b0;
		end
	end

	always_comb begin
		groups   = {1'b0, group_count_q} + {4'd0, (group_digits_q != 3'd0)};
		v4_match = v4_ok_q && (octet_count_q == ipatc_pkg::DOTS_NEEDED)
			&& (octet_digits_q != 2'd0);
		v6_match = v6_ok_q && (last_colon_q != ipatc_pkg::COLON_SINGLE)
			&& (last_colon_q != ipatc_pkg::COLON_LEADING);
		if (double_colon_q) begin
			if (groups > ipatc_pkg::GROUPS_WITH_GAP)
				v6_match = 1'b0;
		end else begin
			if (groups != ipatc_pkg::GROUPS_FULL)
				v6_match = 1'b0;
		end

		verdict_d = ipatc_pkg::VERDICT_INVALID;
		if (char_count_q == 6'd0 || bad_char_q || char_count_q > ipatc_pkg::MAX_TEXT_LEN) begin
			verdict_d = ipatc_pkg::VERDICT_INVALID;
		end else if (seen_colon_q) begin
			if (v6_match && !seen_dot_q)
				verdict_d = ipatc_pkg::VERDICT_V6;
		end else if (seen_dot_q) begin
			if (v4_match)
				verdict_d = ipatc_pkg::VERDICT_V4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_colon_q   <= 1'b0;
			seen_dot_q     <= 1'b0;
			bad_char_q     <= 1'b0;
			char_count_q   <= 6'd0;
			v4_ok_q        <= 1'b1;
			octet_value_q  <= 9'd0;
			octet_digits_q <= 2'd0;
			octet_count_q  <= 3'd0;
			v6_ok_q        <= 1'b1;
			group_digits_q <= 3'd0;
			group_count_q  <= 4'd0;
			double_colon_q <= 1'b0;
			last_colon_q   <= ipatc_pkg::COLON_NONE;
		end else if (step) begin
			if (is_end) begin
				// The terminator ends the string: return to the start state.
				seen_colon_q   <= 1'b0;
				seen_dot_q     <= 1'b0;
				bad_char_q     <= 1'b0;
				char_count_q   <= 6'd0;
				v4_ok_q        <= 1'b1;
				octet_value_q  <= 9'd0;
				octet_digits_q <= 2'd0;
				octet_count_q  <= 3'd0;
				v6_ok_q        <= 1'b1;
				group_digits_q <= 3'd0;
				group_count_q  <= 4'd0;
				double_colon_q <= 1'b0;
				last_colon_q   <= ipatc_pkg::COLON_NONE;
			end else begin
				seen_colon_q   <= seen_colon_n;
				seen_dot_q     <= seen_dot_n;
				bad_char_q     <= bad_char_n;
				char_count_q   <= char_count_n;
				v4_ok_q        <= v4_ok_n;
				octet_value_q  <= octet_value_n;
				octet_digits_q <= octet_digits_n;
				octet_count_q  <= octet_count_n;
				v6_ok_q        <= v6_ok_n;
				group_digits_q <= group_digits_n;
				group_count_q  <= group_count_n;
				double_colon_q <= double_colon_n;
				last_colon_q   <= last_colon_n;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_end) |=> (char_count_q == 6'd0 && v4_ok_q && v6_ok_q))
		else $error("state not cleared after terminator");

	a_octet_bound: assert property (@(posedge clk) disable iff (!arst_n)
		octet_value_q <= ipatc_pkg::OCTET_SAT)
		else $error("octet value beyond saturation");

endmodule
